/* sv/wma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_pkg
// Shared types and constants of the windowed moving average: controller
// states, the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned WL_W   = 7;

    localparam logic [WL_W-1:0] WL_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic update;
        logic load_div;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic out_busy;
    } sts_t;

endpackage : wma_pkg
`default_nettype wire

/* sv/wma_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_ctrl
// Sequencer for one sample: ring update, divider load, serial divide steps
// (only with a full window) and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module wma_ctrl #(
    parameter int unsigned DIV_STEPS = 38
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire wma_pkg::sts_t sts,
    output wma_pkg::cmd_t      cmd
);

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    wma_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wma_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            wma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = wma_pkg::ST_UPDATE;
                end
            end
            wma_pkg::ST_UPDATE: begin
                state_next = wma_pkg::ST_LOAD;
            end
            wma_pkg::ST_LOAD: begin
                cnt_next = '0;
                if (sts.full) begin
                    state_next = wma_pkg::ST_DIV;
                end else begin
                    state_next = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DONE: begin
                if (!sts.out_busy) begin
                    state_next = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wma_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            wma_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            wma_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            wma_pkg::ST_LOAD: begin
                cmd.load_div = 1'b1;
            end
            wma_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            wma_pkg::ST_DONE: begin
                cmd.load_out = !sts.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule : wma_ctrl
`default_nettype wire

/* sv/wma_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wma_dp
// Datapath: sample ring memory, write position, fill count, running sum,
// radix-2 restoring divider and the output register.
// ----------------------------------------------------------------------------
module wma_dp #(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned SUM_W       = 38
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [wma_pkg::WL_W-1:0]    cfg_wr_data,
    input  wire logic [wma_pkg::DATA_W-1:0]  s_tdata,
    input  wire wma_pkg::cmd_t               cmd,
    output wma_pkg::sts_t                    sts,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [wma_pkg::DATA_W-1:0]       m_tdata,
    output logic                             m_tuser
);

    localparam int unsigned POS_W = $clog2(MAX_WINDOW);
    localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int unsigned CMP_W = (LEN_W > wma_pkg::WL_W) ? LEN_W : wma_pkg::WL_W;
    localparam int unsigned LEN_RESET_I =
        (MAX_WINDOW < 64) ? MAX_WINDOW : 64;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(LEN_RESET_I);
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_WINDOW);

    // ring memory
    logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] old_reg;

    logic [LEN_W-1:0]        len_reg, len_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [LEN_W-1:0]        fill_reg, fill_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]  sample_reg;

    logic [SUM_W-1:0]        div_q_reg, div_q_next;
    logic [LEN_W-1:0]        div_rem_reg, div_rem_next;
    logic                    neg_reg;
    logic                    full_reg;

    logic                    m_tvalid_reg;
    logic [wma_pkg::DATA_W-1:0] m_tdata_reg;
    logic                    m_tuser_reg;

    logic [CMP_W-1:0]        wl_cmp;
    logic [LEN_W-1:0]        len_cfg;
    logic                    full_now;
    logic [LEN_W:0]          rem_shift;
    logic [LEN_W:0]          rem_diff;
    logic [SUM_W-1:0]        sum_mag;
    logic [SUM_W-1:0]        quot;
    logic [wma_pkg::DATA_W-1:0] avg;

    // effective window length from the written register value
    always_comb begin
        wl_cmp = CMP_W'(cfg_wr_data);
        if (cfg_wr_data == '0) begin
            len_cfg = LEN_W'(1);
        end else if (wl_cmp > MAX_CMP) begin
            len_cfg = LEN_W'(MAX_WINDOW);
        end else begin
            len_cfg = LEN_W'(wl_cmp);
        end
    end

    assign full_now = (fill_reg == len_reg);

    always_comb begin
        len_next  = len_reg;
        pos_next  = pos_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (cfg_wr_en) begin
            len_next  = len_cfg;
            pos_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end else if (cmd.update) begin
            sum_next = sum_reg + SUM_W'($signed(sample_reg))
                     - (full_now ? SUM_W'($signed(old_reg)) : SUM_W'(0));
            if (!full_now) begin
                fill_next = fill_reg + 1'b1;
            end
            if (LEN_W'(pos_reg) + 1'b1 == len_reg) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg  <= LEN_RESET;
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end else begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            old_reg    <= ring_mem[pos_reg];
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (cmd.update) begin
            ring_mem[pos_reg] <= sample_reg;
        end
    end

    // radix-2 restoring divider on the sum magnitude
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign rem_shift = {div_rem_reg, div_q_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, len_reg};

    always_comb begin
        div_q_next   = div_q_reg;
        div_rem_next = div_rem_reg;
        if (cmd.load_div) begin
            div_q_next   = sum_mag;
            div_rem_next = '0;
        end else if (cmd.div_step) begin
            div_q_next = {div_q_reg[SUM_W-2:0], !rem_diff[LEN_W]};
            if (!rem_diff[LEN_W]) begin
                div_rem_next = rem_diff[LEN_W-1:0];
            end else begin
                div_rem_next = rem_shift[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        if (cmd.load_div) begin
            neg_reg  <= sum_reg[SUM_W-1];
            full_reg <= full_now;
        end
    end

    assign quot = neg_reg ? (~div_q_reg + 1'b1) : div_q_reg;
    assign avg  = full_reg ? wma_pkg::DATA_W'($signed(quot[SAMPLE_BITS-1:0])) : '0;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= avg;
            m_tuser_reg <= full_reg;
        end
    end

    assign sts.full     = full_now;
    assign sts.out_busy = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule : wma_dp
`default_nettype wire

/* sv/windowed_moving_average.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_moving_average
// Simple moving average over a ring of the last window_length samples.
// Each sample runs through ring update, divider load, the serial divide steps
//   (skipped while the window is still filling) and the output register.
// One sample is in flight at a time; the next is taken once the result is in
//   the output register. The serial divider gives one quotient bit per cycle.
// Reset: window length 64, ring empty, running sum and fill count zero.
// ----------------------------------------------------------------------------
module windowed_moving_average #(
    parameter int unsigned MAX_WINDOW  = 64,
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [wma_pkg::WL_W-1:0]    cfg_wr_data,  // window_length
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [wma_pkg::DATA_W-1:0]  s_tdata,      // [31:0] sample
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [wma_pkg::DATA_W-1:0]       m_tdata,      // [31:0] average
    output logic                             m_tuser       // [0] window_full
);

    localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    wma_pkg::cmd_t cmd;
    wma_pkg::sts_t sts;

    wma_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wma_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // a mean is only reported with a full window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("average non-zero while window not full");

    // one sample in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in flight");

    // controller issues at most one command per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.update, cmd.load_div, cmd.div_step, cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule : windowed_moving_average
`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for windowed_moving_average. Samples go in over the
// input stream. Each transfer is run through a behavioural copy of the ring,
// the fill count and the wide running sum. Every average that comes out is
// compared with the oldest pending prediction. Window lengths are rewritten
// between phases, including zero, one and values above the ring depth. The
// input and output sides idle and stall in several patterns, and there is
// one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int RING_DEPTH   = 64;
    localparam int DRAIN_CYCLES = 50;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 130;

    localparam logic [wma_pkg::DATA_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
    localparam logic [wma_pkg::DATA_W-1:0] SAMPLE_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic [wma_pkg::DATA_W-1:0] average;
        logic                       window_full;
    } mean_result_t;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [wma_pkg::WL_W-1:0]   cfg_wr_data = '0;
    logic                       s_tvalid    = 1'b0;
    logic                       s_tready;
    logic [wma_pkg::DATA_W-1:0] s_tdata     = '0;
    logic                       m_tvalid;
    logic                       m_tready    = 1'b0;
    logic [wma_pkg::DATA_W-1:0] m_tdata;
    logic                       m_tuser;

    // behavioural copy of the window
    logic [wma_pkg::WL_W-1:0]          win_len_q = wma_pkg::WL_RESET;
    logic signed [wma_pkg::DATA_W-1:0] hist_q [RING_DEPTH];
    int unsigned                       wr_pos_q  = 0;
    int unsigned                       fill_q    = 0;
    longint                            sum_q     = 0;

    mean_result_t expected_means[$];

    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    logic hold_off       = 1'b0;
    int   errors         = 0;
    int   samples_sent   = 0;
    int   means_checked  = 0;
    int   full_means     = 0;
    int   window_writes  = 0;
    int   idle_cycles    = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    windowed_moving_average u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    function automatic int unsigned active_length();
        if (win_len_q == '0) return 1;
        if (win_len_q > RING_DEPTH) return RING_DEPTH;
        return win_len_q;
    endfunction

    function automatic mean_result_t predict_mean(input logic [wma_pkg::DATA_W-1:0] raw);
        int unsigned                       len;
        int unsigned                       pos;
        logic signed [wma_pkg::DATA_W-1:0] smp;
        longint                            quot;
        mean_result_t                      res;
        len = active_length();
        smp = raw;
        pos = wr_pos_q;
        if (pos >= len) pos = 0;
        if (fill_q > len) fill_q = len;
        // once full, the oldest sample leaves the sum before being overwritten
        if (fill_q == len) sum_q -= hist_q[pos];
        else fill_q++;
        hist_q[pos] = smp;
        sum_q += smp;
        pos++;
        if (pos >= len) pos = 0;
        wr_pos_q = pos;
        res.window_full = (fill_q == len);
        if (res.window_full) begin
            quot        = sum_q / longint'(len);
            res.average = quot[wma_pkg::DATA_W-1:0];
        end else begin
            res.average = '0;
        end
        return res;
    endfunction

    function automatic logic [wma_pkg::DATA_W-1:0] random_sample();
        case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return $urandom_range(16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            IDLE_SRC:  begin src_idle_pct = 84; sink_stall_pct = 0;  end
            IDLE_SINK: begin src_idle_pct = 0;  sink_stall_pct = 84; end
            default:   begin src_idle_pct = 14; sink_stall_pct = 14; end
        endcase
    endfunction

    task automatic push_sample(input logic [wma_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_means.push_back(predict_mean(value));
        samples_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [wma_pkg::WL_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        win_len_q = len;
        wr_pos_q  = 0;
        fill_q    = 0;
        sum_q     = 0;
        window_writes++;
    endtask

    task automatic hold_sink(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge aclk);
        hold_off <= 1'b0;
    endtask

    task automatic test_reset_length();
        set_idling(IDLE_NONE);
        push_sample(32'h0000_0001);
        push_sample(32'hFFFF_FFFF);
        push_sample(SAMPLE_MAX);
    endtask

    // zero length behaves as a window of one
    task automatic test_zero_length();
        write_window(7'd0);
        set_idling(IDLE_BOTH);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MAX);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h0000_0001);
        push_sample(32'h5555_5555);
        push_sample(32'hAAAA_AAAA);
    endtask

    // ring wrap, oldest sample dropped, truncation toward zero
    task automatic test_window_two();
        write_window(7'd2);
        set_idling(IDLE_NONE);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MAX);
        push_sample(SAMPLE_MIN);
        push_sample(SAMPLE_MIN);
        push_sample(32'hFFFF_FFFD);
        push_sample(32'h0000_0000);
        push_sample(32'h0000_0003);
        push_sample(32'h0000_0000);
    endtask

    task automatic test_backpressure();
        write_window(7'd4);
        set_idling(IDLE_NONE);
        fork
            hold_sink(HOLD_CYCLES);
        join_none
        repeat (24) push_sample(random_sample());
    endtask

    task automatic test_random_windows();
        logic [wma_pkg::WL_W-1:0] lengths [9];
        lengths    = '{7'd3, 7'd64, 7'd127, 7'd1, 7'd65, 7'd17, 7'd0, 7'd2, 7'd40};
        lengths[6] = wma_pkg::WL_W'($urandom_range(127));
        for (int i = 0; i < 9; i++) begin
            write_window(lengths[i]);
            set_idling(idle_mode_t'(i % 4));
            repeat (PHASE_ITEMS) push_sample(random_sample());
        end
    endtask

    // full ring of one extreme drives the running sum to its widest
    task automatic test_wide_sum();
        write_window(7'd64);
        set_idling(IDLE_SINK);
        repeat (80) push_sample(($urandom_range(9) != 0) ? SAMPLE_MAX : $urandom());
        set_idling(IDLE_SRC);
        repeat (80) push_sample(($urandom_range(9) != 0) ? SAMPLE_MIN : $urandom());
    endtask

    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        mean_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_means.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, average %h full %b",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_means.pop_front();
                if (m_tdata !== want.average) begin
                    errors++;
                    $display("%0t: average expected %h actual %h",
                             $time, want.average, m_tdata);
                end
                if (m_tuser !== want.window_full) begin
                    errors++;
                    $display("%0t: window_full expected %b actual %b",
                             $time, want.window_full, m_tuser);
                end
                if (want.window_full) full_means++;
            end
            means_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d averages outstanding",
                     $time, idle_cycles, expected_means.size());
            $display("[windowed_moving_average] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_length();
        test_zero_length();
        test_window_two();
        test_backpressure();
        test_random_windows();
        test_wide_sum();
        drain();
        $display("run covered %0d samples and %0d averages, %0d of them over a full window",
                 samples_sent, means_checked, full_means);
        $display("%0d window lengths written, from zero up past the ring depth; %0d errors",
                 window_writes, errors);
        if (errors == 0) begin
            $display("[windowed_moving_average] OK");
        end else begin
            $display("[windowed_moving_average] ERROR");
        end
        $finish;
    end

endmodule

/* windowed_moving_average.f */
sv/wma_pkg.sv
sv/wma_ctrl.sv
sv/wma_dp.sv
sv/windowed_moving_average.sv
bench/tb.sv
